@@ hw/rtl/lts_pkg.sv @@
package lts_pkg;

  // Upper bound on credential slots that an attempt sequence walks through
  localparam int unsigned MAX_CREDENTIALS = 2;

  localparam logic [13:0] MIN_YEAR = 14'd2020;

  localparam logic OP_POLL    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CRED_COUNT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOT_TIME       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOT_DELAY      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_TIMEOUT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_WAIT       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRESH         = 3'd6;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_CONNECT = 3'd1,
    PH_SERVICE = 3'd2,
    PH_SYNCED  = 3'd3,
    PH_FAILED  = 3'd4
  } lts_phase_t;

  typedef enum logic [2:0] {
    ST_NO_CONFIG  = 3'd0,
    ST_LINKING    = 3'd1,
    ST_SYNCING    = 3'd2,
    ST_NO_NETWORK = 3'd3,
    ST_SYNCED     = 3'd4,
    ST_NO_TIME    = 3'd5
  } lts_status_t;

  typedef struct packed {
    logic [1:0]  cred_count;
    logic [31:0] boot_time_ms;
    logic [31:0] boot_delay_ms;
    logic [31:0] connect_timeout_ms;
    logic [31:0] service_timeout_ms;
    logic [31:0] fail_wait_ms;
    logic [31:0] refresh_interval_ms;
  } lts_cfg_t;

  localparam lts_cfg_t CFG_RESET = '{
    cred_count:          2'd0,
    boot_time_ms:        32'd0,
    boot_delay_ms:       32'd3000,
    connect_timeout_ms:  32'd15000,
    service_timeout_ms:  32'd12000,
    fail_wait_ms:        32'd300000,
    refresh_interval_ms: 32'd21600000
  };

  typedef struct packed {
    lts_phase_t  phase;
    logic [31:0] phase_start_ms;
    logic [1:0]  attempt_index;
    logic        force_pending;
    logic        synced_once;
    logic [31:0] last_ok_ms;
    logic [31:0] retry_at_ms;
  } lts_state_t;

  localparam lts_state_t STATE_RESET = '{
    phase:          PH_IDLE,
    phase_start_ms: 32'd0,
    attempt_index:  2'd0,
    force_pending:  1'b0,
    synced_once:    1'b0,
    last_ok_ms:     32'd0,
    retry_at_ms:    32'd0
  };

  typedef struct packed {
    logic        operation;
    logic [31:0] now_ms;
    logic        host_time_present;
    logic        link_up;
    logic        time_ready;
    logic [13:0] cand_year;
    logic [3:0]  cand_month;
    logic [4:0]  cand_day;
    logic [4:0]  cand_hour;
    logic [5:0]  cand_minute;
    logic [5:0]  cand_second;
  } lts_item_t;

  typedef struct packed {
    logic [2:0]  status_code;
    logic        connect_start;
    logic        slot;
    logic        link_off;
    logic        time_captured;
    logic        ever_synced;
    logic [13:0] sync_year;
    logic [3:0]  sync_month;
    logic [4:0]  sync_day;
    logic [4:0]  sync_hour;
    logic [5:0]  sync_minute;
    logic [5:0]  sync_second;
  } lts_result_t;

endpackage

@@ hw/rtl/lts_if.sv @@
interface lts_in_if import lts_pkg::*; ();
  logic      valid;
  logic      ready;
  lts_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lts_out_if import lts_pkg::*; ();
  logic        valid;
  logic        ready;
  lts_result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/lts_cfg_regs.sv @@
module lts_cfg_regs import lts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output lts_cfg_t              cfg
);

  lts_cfg_t cfg_r;
  lts_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CRED_COUNT:      cfg_nxt.cred_count          = cfg_wdata[1:0];
        CFG_BOOT_TIME:       cfg_nxt.boot_time_ms        = cfg_wdata;
        CFG_BOOT_DELAY:      cfg_nxt.boot_delay_ms       = cfg_wdata;
        CFG_CONNECT_TIMEOUT: cfg_nxt.connect_timeout_ms  = cfg_wdata;
        CFG_SERVICE_TIMEOUT: cfg_nxt.service_timeout_ms  = cfg_wdata;
        CFG_FAIL_WAIT:       cfg_nxt.fail_wait_ms        = cfg_wdata;
        CFG_REFRESH:         cfg_nxt.refresh_interval_ms = cfg_wdata;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/lts_step.sv @@
module lts_step import lts_pkg::*; (
  input  lts_cfg_t    cfg,
  input  lts_state_t  st,
  input  lts_item_t   item,
  output lts_state_t  st_nxt,
  output lts_result_t res
);

  logic [31:0] since_boot;
  logic [31:0] since_phase;
  logic [31:0] since_ok;
  logic [31:0] retry_sum;
  logic [1:0]  attempt_inc;
  logic [3:0]  creds;
  logic        stale;
  logic        need;
  logic        advance;
  logic        conn;
  logic        off;
  logic        cap;
  lts_status_t status;

  assign since_boot  = item.now_ms - cfg.boot_time_ms;
  assign since_phase = item.now_ms - st.phase_start_ms;
  assign since_ok    = item.now_ms - st.last_ok_ms;
  assign retry_sum   = item.now_ms + cfg.fail_wait_ms;
  assign attempt_inc = st.attempt_index + 2'd1;
  assign creds       = ({2'b00, cfg.cred_count} > 4'(MAX_CREDENTIALS)) ?
                       4'(MAX_CREDENTIALS) : {2'b00, cfg.cred_count};
  assign stale       = !st.synced_once || (since_ok >= cfg.refresh_interval_ms);
  assign need        = st.force_pending || (!item.host_time_present && stale);

  always_comb begin
    st_nxt  = st;
    advance = 1'b0;
    conn    = 1'b0;
    off     = 1'b0;
    cap     = 1'b0;
    if (item.operation == OP_REQUEST) begin
      st_nxt.force_pending = 1'b1;
      st_nxt.retry_at_ms   = 32'd0;
    end else if (since_boot >= cfg.boot_delay_ms) begin
      unique case (st.phase)
        PH_IDLE: begin
          if (need) begin
            st_nxt.force_pending = 1'b0;
            if (cfg.cred_count == 2'd0) begin
              st_nxt.phase       = PH_FAILED;
              st_nxt.retry_at_ms = retry_sum;
            end else begin
              st_nxt.attempt_index  = 2'd0;
              st_nxt.phase_start_ms = item.now_ms;
              st_nxt.phase          = PH_CONNECT;
              conn                  = 1'b1;
            end
          end
        end
        PH_CONNECT: begin
          if (item.link_up) begin
            st_nxt.phase_start_ms = item.now_ms;
            st_nxt.phase          = PH_SERVICE;
          end else if (since_phase > cfg.connect_timeout_ms) begin
            off     = 1'b1;
            advance = 1'b1;
          end
        end
        PH_SERVICE: begin
          if (item.time_ready && (item.cand_year >= MIN_YEAR)) begin
            cap                = 1'b1;
            off                = 1'b1;
            st_nxt.synced_once = 1'b1;
            st_nxt.last_ok_ms  = item.now_ms;
            st_nxt.phase       = PH_SYNCED;
          end else if (since_phase > cfg.service_timeout_ms) begin
            off     = 1'b1;
            advance = 1'b1;
          end
        end
        PH_SYNCED: begin
          if (since_ok >= cfg.refresh_interval_ms) begin
            st_nxt.phase = PH_IDLE;
          end
        end
        default: begin
          if (st.force_pending ||
              ((st.retry_at_ms != 32'd0) && (item.now_ms >= st.retry_at_ms))) begin
            st_nxt.retry_at_ms = 32'd0;
            st_nxt.phase       = PH_IDLE;
          end
        end
      endcase
      // Move to the next credential slot, or give up and schedule a retry
      if (advance) begin
        st_nxt.attempt_index = attempt_inc;
        if ({2'b00, attempt_inc} < creds) begin
          st_nxt.phase_start_ms = item.now_ms;
          st_nxt.phase          = PH_CONNECT;
          conn                  = 1'b1;
        end else begin
          st_nxt.phase       = PH_FAILED;
          st_nxt.retry_at_ms = retry_sum;
        end
      end
    end
  end

  always_comb begin
    if (cfg.cred_count == 2'd0) begin
      status = ST_NO_CONFIG;
    end else begin
      unique case (st_nxt.phase)
        PH_CONNECT: status = ST_LINKING;
        PH_SERVICE: status = ST_SYNCING;
        PH_FAILED:  status = ST_NO_NETWORK;
        default:    status = st_nxt.synced_once ? ST_SYNCED : ST_NO_TIME;
      endcase
    end
  end

  always_comb begin
    res               = '0;
    res.status_code   = status;
    res.connect_start = conn;
    res.slot          = st_nxt.attempt_index[0];
    res.link_off      = off;
    res.time_captured = cap;
    res.ever_synced   = st_nxt.synced_once;
    if (cap) begin
      res.sync_year   = item.cand_year;
      res.sync_month  = item.cand_month;
      res.sync_day    = item.cand_day;
      res.sync_hour   = item.cand_hour;
      res.sync_minute = item.cand_minute;
      res.sync_second = item.cand_second;
    end
  end

endmodule

@@ hw/rtl/link_time_sync_supervisor_core.sv @@
// Link time sync supervisor.
// in_ch carries poll and request items (valid/ready); a transfer happens on
// a rising edge with both high. Every accepted item yields exactly one result
// on out_ch, in order: status code, connect and link-off pulses, the current
// credential slot and, on a fresh sync, the captured calendar time.
// cfg_we/cfg_index/cfg_wdata write the timing and credential registers; write
// them only while no item is in flight.
// An item transferred on in_ch is held in the input register, then evaluated
// into the result register, which shows it from then on. Throughput: one item
// per cycle while the receiver keeps up, set by the single evaluation stage
// between the input register and the result register.
// Reset (rst_n low at a clock edge) returns the phase machine to idle with no
// sync history and loads the default timeouts; both stages empty.
// When the receiver stalls, the result register holds its value, the input
// register holds one more item, and in_ch.ready drops only when both are full.
module link_time_sync_supervisor_core import lts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  lts_in_if.sink                in_ch,
  lts_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  lts_cfg_t    cfg;

  // Input stage
  logic        in_valid_r;
  logic        in_valid_nxt;
  lts_item_t   in_item_r;

  // Supervisor state
  lts_state_t  st_r;
  lts_state_t  st_nxt;

  // Result stage
  logic        out_valid_r;
  logic        out_valid_nxt;
  lts_result_t out_data_r;
  lts_result_t res;

  logic        in_xfer;
  logic        eval;

  lts_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lts_step u_step (
    .cfg    (cfg),
    .st     (st_r),
    .item   (in_item_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // Evaluate the held item whenever the result register is free or draining
  assign eval         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || eval;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  assign in_valid_nxt  = in_xfer ? 1'b1 : (eval ? 1'b0 : in_valid_r);
  assign out_valid_nxt = eval ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= STATE_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (eval) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers: load on transfer / evaluation, hold otherwise
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r <= in_ch.data;
    end
    if (eval) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // A captured time always leaves the machine synced with history set
  a_capture_synced: assert property (@(posedge clk) disable iff (!rst_n)
    eval && res.time_captured |=> (st_r.phase == PH_SYNCED) && st_r.synced_once)
    else $error("time capture did not land in the synced phase");

  // A connect pulse always starts a connect phase at the item's time
  a_connect_phase: assert property (@(posedge clk) disable iff (!rst_n)
    eval && res.connect_start |=>
      (st_r.phase == PH_CONNECT) && (st_r.phase_start_ms == $past(in_item_r.now_ms)))
    else $error("connect pulse without entering the connect phase");

  // An empty input stage always takes a transfer
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_ch.ready)
    else $error("input stalled with an empty input stage");

  // Time fields stay clear unless a capture is reported
  a_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.time_captured |->
      (out_data_r.sync_year == 14'd0) && (out_data_r.sync_second == 6'd0))
    else $error("time fields set without a capture");

endmodule

@@ tb/link_time_sync_supervisor_core_tb.sv @@
module link_time_sync_supervisor_core_tb;
  import lts_pkg::*;

  // Run shape: a directed table first, then randomized phases with their own
  // register settings and their own idle/stall mix.
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned RAND_PHASES     = 8;
  localparam int unsigned ITEMS_PER_PHASE = 75;
  localparam int unsigned HOLD_CYCLES     = 120;
  localparam int unsigned MAX_GAP         = 60;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // One line of the directed table: either an item (with an optional
  // hand-written expectation) or a register write.
  typedef struct {
    row_kind_t            kind;
    lts_item_t            item;
    bit                   has_exp;
    lts_result_t          exp;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [31:0]          reg_val;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lts_in_if  in_if ();
  lts_out_if out_if ();

  link_time_sync_supervisor_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the supervisor: registers and phase machine state.
  lts_cfg_t    sup_cfg;
  lts_state_t  sup_st;

  // Reports still owed by the block, oldest first.
  lts_result_t pending_reports[$];

  // Hand-written expectation for the item currently offered.
  bit          typed_valid;
  lts_result_t typed_exp;

  // Traffic knobs: idle and stall chances in percent per cycle, and a receiver hold-off.
  int unsigned idle_pct;
  int unsigned stall_pct;
  bit          hold_request;
  int unsigned hold_left;

  int unsigned errors;
  int unsigned reports_checked;
  int unsigned syncs_seen;
  int unsigned cycle_count;

  // Running wall clock for the random part.
  logic [31:0] now_clock;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow supervisor
  // ---------------------------------------------------------------------

  // Wrapping millisecond distance from mark to now.
  function automatic logic [31:0] ms_since(logic [31:0] now, logic [31:0] mark);
    return now - mark;
  endfunction

  function automatic lts_status_t status_of();
    if (sup_cfg.cred_count == 2'd0) return ST_NO_CONFIG;
    case (sup_st.phase)
      PH_CONNECT: return ST_LINKING;
      PH_SERVICE: return ST_SYNCING;
      PH_FAILED:  return ST_NO_NETWORK;
      default:    return sup_st.synced_once ? ST_SYNCED : ST_NO_TIME;
    endcase
  endfunction

  // Move on to the next credential slot, or give up and schedule a retry.
  // Returns the connect pulse.
  function automatic bit next_slot_or_fail(logic [31:0] now);
    logic [1:0] usable;
    usable = (sup_cfg.cred_count > MAX_CREDENTIALS) ? 2'(MAX_CREDENTIALS)
                                                    : sup_cfg.cred_count;
    sup_st.attempt_index = sup_st.attempt_index + 2'd1;
    if (sup_st.attempt_index < usable) begin
      sup_st.phase_start_ms = now;
      sup_st.phase = PH_CONNECT;
      return 1'b1;
    end
    sup_st.phase = PH_FAILED;
    sup_st.retry_at_ms = now + sup_cfg.fail_wait_ms;
    return 1'b0;
  endfunction

  // Apply one transferred item to the shadow state and build its report.
  function automatic lts_result_t advance_supervisor(lts_item_t it);
    lts_result_t r;
    logic [31:0] now;
    bit          stale;
    bit          conn;
    bit          off;
    bit          cap;
    r    = '0;
    conn = 1'b0;
    off  = 1'b0;
    cap  = 1'b0;
    now  = it.now_ms;
    if (it.operation == OP_REQUEST) begin
      sup_st.force_pending = 1'b1;
      sup_st.retry_at_ms = '0;
    end else if (ms_since(now, sup_cfg.boot_time_ms) >= sup_cfg.boot_delay_ms) begin
      case (sup_st.phase)
        PH_IDLE: begin
          stale = !sup_st.synced_once ||
                  ms_since(now, sup_st.last_ok_ms) >= sup_cfg.refresh_interval_ms;
          if (sup_st.force_pending || (!it.host_time_present && stale)) begin
            sup_st.force_pending = 1'b0;
            if (sup_cfg.cred_count == 2'd0) begin
              sup_st.phase = PH_FAILED;
              sup_st.retry_at_ms = now + sup_cfg.fail_wait_ms;
            end else begin
              sup_st.attempt_index = 2'd0;
              sup_st.phase_start_ms = now;
              sup_st.phase = PH_CONNECT;
              conn = 1'b1;
            end
          end
        end
        PH_CONNECT: begin
          if (it.link_up) begin
            sup_st.phase_start_ms = now;
            sup_st.phase = PH_SERVICE;
          end else if (ms_since(now, sup_st.phase_start_ms) > sup_cfg.connect_timeout_ms) begin
            off = 1'b1;
            conn = next_slot_or_fail(now);
          end
        end
        PH_SERVICE: begin
          if (it.time_ready && it.cand_year >= MIN_YEAR) begin
            cap = 1'b1;
            sup_st.synced_once = 1'b1;
            sup_st.last_ok_ms = now;
            sup_st.phase = PH_SYNCED;
            off = 1'b1;
          end else if (ms_since(now, sup_st.phase_start_ms) > sup_cfg.service_timeout_ms) begin
            off = 1'b1;
            conn = next_slot_or_fail(now);
          end
        end
        PH_SYNCED: begin
          if (ms_since(now, sup_st.last_ok_ms) >= sup_cfg.refresh_interval_ms)
            sup_st.phase = PH_IDLE;
        end
        default: begin
          // failed: leave on a forced request or once the retry time is due
          if (sup_st.force_pending ||
              (sup_st.retry_at_ms != 32'd0 && now >= sup_st.retry_at_ms)) begin
            sup_st.retry_at_ms = '0;
            sup_st.phase = PH_IDLE;
          end
        end
      endcase
    end
    r.status_code   = status_of();
    r.connect_start = conn;
    r.slot          = sup_st.attempt_index[0];
    r.link_off      = off;
    r.time_captured = cap;
    r.ever_synced   = sup_st.synced_once;
    if (cap) begin
      r.sync_year   = it.cand_year;
      r.sync_month  = it.cand_month;
      r.sync_day    = it.cand_day;
      r.sync_hour   = it.cand_hour;
      r.sync_minute = it.cand_minute;
      r.sync_second = it.cand_second;
    end
    return r;
  endfunction

  function automatic void write_shadow_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    case (idx)
      CFG_CRED_COUNT:      sup_cfg.cred_count          = v[1:0];
      CFG_BOOT_TIME:       sup_cfg.boot_time_ms        = v;
      CFG_BOOT_DELAY:      sup_cfg.boot_delay_ms       = v;
      CFG_CONNECT_TIMEOUT: sup_cfg.connect_timeout_ms  = v;
      CFG_SERVICE_TIMEOUT: sup_cfg.service_timeout_ms  = v;
      CFG_FAIL_WAIT:       sup_cfg.fail_wait_ms        = v;
      CFG_REFRESH:         sup_cfg.refresh_interval_ms = v;
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: predict on every input transfer, check on every output transfer
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    lts_result_t predicted;
    lts_result_t want;
    if (rst_n) begin
      if (cfg_we) write_shadow_reg(cfg_index, cfg_wdata);
      if (in_if.valid && in_if.ready) begin
        predicted = advance_supervisor(in_if.data);
        pending_reports.push_back(typed_valid ? typed_exp : predicted);
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_reports.size() == 0) begin
          errors++;
          $display("%0t: unexpected report, expected none, got %p", $time, out_if.data);
        end else begin
          want = pending_reports.pop_front();
          check_field("status_code",   want.status_code,   out_if.data.status_code);
          check_field("connect_start", want.connect_start, out_if.data.connect_start);
          check_field("slot",          want.slot,          out_if.data.slot);
          check_field("link_off",      want.link_off,      out_if.data.link_off);
          check_field("time_captured", want.time_captured, out_if.data.time_captured);
          check_field("ever_synced",   want.ever_synced,   out_if.data.ever_synced);
          check_field("sync_year",     want.sync_year,     out_if.data.sync_year);
          check_field("sync_month",    want.sync_month,    out_if.data.sync_month);
          check_field("sync_day",      want.sync_day,      out_if.data.sync_day);
          check_field("sync_hour",     want.sync_hour,     out_if.data.sync_hour);
          check_field("sync_minute",   want.sync_minute,   out_if.data.sync_minute);
          check_field("sync_second",   want.sync_second,   out_if.data.sync_second);
          reports_checked++;
          if (out_if.data.time_captured) syncs_seen++;
        end
      end
    end
  end

  // Watchdog: give up well past the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d reports outstanding", $time, pending_reports.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic lts_item_t mk_item(logic op, logic [31:0] now, logic host, logic link,
                                        logic tready, logic [13:0] year = 14'd0,
                                        logic [3:0] mon = 4'd1, logic [4:0] day = 5'd1,
                                        logic [4:0] hr = 5'd0, logic [5:0] mn = 6'd0,
                                        logic [5:0] sec = 6'd0);
    lts_item_t it;
    it.operation         = op;
    it.now_ms            = now;
    it.host_time_present = host;
    it.link_up           = link;
    it.time_ready        = tready;
    it.cand_year         = year;
    it.cand_month        = mon;
    it.cand_day          = day;
    it.cand_hour         = hr;
    it.cand_minute       = mn;
    it.cand_second       = sec;
    return it;
  endfunction

  function automatic lts_result_t status_only(lts_status_t st, bit conn, bit slot, bit off);
    lts_result_t r;
    r = '0;
    r.status_code   = st;
    r.connect_start = conn;
    r.slot          = slot;
    r.link_off      = off;
    return r;
  endfunction

  // Offer one item after a random idle gap and hold it until transferred.
  task automatic send_item(lts_item_t it, bit has_exp = 1'b0, lts_result_t exp = '0);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    typed_valid = has_exp;
    typed_exp   = exp;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Drop valid, then wait until every owed report has come back.
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : main
    dir_row_t    rows[$];
    dir_row_t    row;
    lts_item_t   it;
    logic [31:0] junk;
    logic [31:0] r_boot, r_delay, r_conn, r_svc, r_fail, r_refresh;
    logic [1:0]  r_cred;
    int unsigned step_max;
    int unsigned dir_items;
    int unsigned rand_items;

    // Hold every input at a known value from time zero.
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    typed_valid  = 1'b0;
    typed_exp    = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_request = 1'b0;
    hold_left    = 0;
    errors       = 0;
    reports_checked = 0;
    syncs_seen   = 0;
    cycle_count  = 0;
    dir_items    = 0;
    rand_items   = 0;
    now_clock    = '0;

    // Shadow reset: defaults written out here rather than taken from the package.
    sup_cfg.cred_count          = 2'd0;
    sup_cfg.boot_time_ms        = 32'd0;
    sup_cfg.boot_delay_ms       = 32'd3000;
    sup_cfg.connect_timeout_ms  = 32'd15000;
    sup_cfg.service_timeout_ms  = 32'd12000;
    sup_cfg.fail_wait_ms        = 32'd300000;
    sup_cfg.refresh_interval_ms = 32'd21600000;
    sup_st.phase          = PH_IDLE;
    sup_st.phase_start_ms = '0;
    sup_st.attempt_index  = '0;
    sup_st.force_pending  = 1'b0;
    sup_st.synced_once    = 1'b0;
    sup_st.last_ok_ms     = '0;
    sup_st.retry_at_ms    = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table. Reset defaults first: no credentials, 3 s boot delay.
    row = '{ROW_ITEM, '0, 1'b0, '0, '0, '0};
    // inside the boot delay nothing moves
    row.item = mk_item(OP_POLL, 32'd0, 1'b0, 1'b0, 1'b0);
    row.has_exp = 1'b1; row.exp = status_only(ST_NO_CONFIG, 0, 0, 0); rows.push_back(row);
    // forced request: flag only, no phase step
    row.item = mk_item(OP_REQUEST, 32'd5, 1'b0, 1'b0, 1'b0);
    rows.push_back(row);
    // forced, but no credentials: straight to failed
    row.item = mk_item(OP_POLL, 32'd3000, 1'b1, 1'b0, 1'b0);
    rows.push_back(row);

    // Short timeouts and a credential count above the slot limit.
    row = '{ROW_REG, '0, 1'b0, '0, CFG_CRED_COUNT, 32'd3};      rows.push_back(row);
    row.reg_idx = CFG_BOOT_DELAY;      row.reg_val = 32'd0;    rows.push_back(row);
    row.reg_idx = CFG_CONNECT_TIMEOUT; row.reg_val = 32'd10;   rows.push_back(row);
    row.reg_idx = CFG_SERVICE_TIMEOUT; row.reg_val = 32'd10;   rows.push_back(row);
    row.reg_idx = CFG_FAIL_WAIT;       row.reg_val = 32'd100;  rows.push_back(row);
    row.reg_idx = CFG_REFRESH;         row.reg_val = 32'd1000; rows.push_back(row);

    row = '{ROW_ITEM, '0, 1'b1, '0, '0, '0};
    // request while failed clears the retry time
    row.item = mk_item(OP_REQUEST, 32'd3010, 1'b1, 1'b0, 1'b0);
    row.exp = status_only(ST_NO_NETWORK, 0, 0, 0); rows.push_back(row);
    // forced retry out of failed
    row.item = mk_item(OP_POLL, 32'd3011, 1'b1, 1'b0, 1'b0);
    row.exp = status_only(ST_NO_TIME, 0, 0, 0); rows.push_back(row);
    // force still pending: start slot 0 despite a host time source
    row.item = mk_item(OP_POLL, 32'd3012, 1'b1, 1'b0, 1'b0);
    row.exp = status_only(ST_LINKING, 1, 0, 0); rows.push_back(row);
    // connect timeout: link off and move to slot 1
    row.item = mk_item(OP_POLL, 32'd3023, 1'b1, 1'b0, 1'b0);
    row.exp = status_only(ST_LINKING, 1, 1, 1); rows.push_back(row);

    row.has_exp = 1'b0;
    row.item = mk_item(OP_POLL, 32'd3030, 1'b0, 1'b1, 1'b0);             rows.push_back(row);
    // year below the floor is refused
    row.item = mk_item(OP_POLL, 32'd3035, 1'b0, 1'b0, 1'b1, 14'd2019);   rows.push_back(row);
    // good year without time_ready, and the service timeout fails the last slot
    row.item = mk_item(OP_POLL, 32'd3041, 1'b0, 1'b0, 1'b0, 14'd2020);   rows.push_back(row);
    row.item = mk_item(OP_POLL, 32'd3100, 1'b0, 1'b0, 1'b0);             rows.push_back(row);
    // scheduled retry reached
    row.item = mk_item(OP_POLL, 32'd3141, 1'b0, 1'b0, 1'b0);             rows.push_back(row);
    row.item = mk_item(OP_POLL, 32'd3142, 1'b0, 1'b0, 1'b0);             rows.push_back(row);
    row.item = mk_item(OP_POLL, 32'd3143, 1'b0, 1'b1, 1'b0);             rows.push_back(row);
    // capture with the year at its floor and every other field at its top
    row.item = mk_item(OP_POLL, 32'd3144, 1'b0, 1'b0, 1'b1, 14'd2020, 4'd12, 5'd31, 5'd23,
                       6'd59, 6'd60);
    rows.push_back(row);
    row.item = mk_item(OP_POLL, 32'd3500, 1'b0, 1'b0, 1'b0);             rows.push_back(row);
    // refresh interval elapsed
    row.item = mk_item(OP_POLL, 32'd4144, 1'b0, 1'b0, 1'b0);             rows.push_back(row);
    // stale, but a host time source is present: stay put
    row.item = mk_item(OP_POLL, 32'd4145, 1'b1, 1'b0, 1'b0);             rows.push_back(row);
    row.item = mk_item(OP_POLL, 32'd4146, 1'b0, 1'b0, 1'b0);             rows.push_back(row);
    row.item = mk_item(OP_POLL, 32'd4147, 1'b0, 1'b1, 1'b0);             rows.push_back(row);
    // capture with every field at its bottom and the year at its top
    row.item = mk_item(OP_POLL, 32'd4148, 1'b0, 1'b0, 1'b1, 14'd9999, 4'd1, 5'd1, 5'd0,
                       6'd0, 6'd0);
    rows.push_back(row);

    // Largest boot delay with the time wrapping around zero.
    row = '{ROW_REG, '0, 1'b0, '0, CFG_BOOT_TIME, 32'd1};        rows.push_back(row);
    row.reg_idx = CFG_BOOT_DELAY; row.reg_val = 32'hFFFF_FFFF;   rows.push_back(row);
    row.reg_idx = CFG_CRED_COUNT; row.reg_val = 32'd1;           rows.push_back(row);
    row = '{ROW_ITEM, '0, 1'b0, '0, '0, '0};
    row.item = mk_item(OP_POLL, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0); rows.push_back(row);
    row.item = mk_item(OP_POLL, 32'd0, 1'b0, 1'b0, 1'b0);         rows.push_back(row);
    row.item = mk_item(OP_REQUEST, 32'd0, 1'b0, 1'b0, 1'b0);      rows.push_back(row);
    row.item = mk_item(OP_POLL, 32'd0, 1'b0, 1'b0, 1'b0);         rows.push_back(row);

    // Walk the table; settle before each run of register writes.
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        if (i == 0 || rows[i-1].kind != ROW_REG) settle();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_item(rows[i].item, rows[i].has_exp, rows[i].exp);
        dir_items++;
      end
    end

    // Random phases: new settings each time, extremes in the first two.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          r_cred = 2'd2; r_boot = '0; r_delay = '0; r_conn = '0; r_svc = '0;
          r_fail = '0; r_refresh = '0; step_max = 2;
        end
        1: begin
          r_cred = 2'd2; r_boot = '0; r_delay = '0; r_conn = '1; r_svc = '1;
          r_fail = '1; r_refresh = '1; step_max = 1000;
        end
        default: begin
          r_cred    = 2'($urandom_range(0, 3));
          r_boot    = $urandom;
          r_delay   = $urandom_range(0, 30);
          r_conn    = $urandom_range(0, 40);
          r_svc     = $urandom_range(0, 40);
          r_fail    = $urandom_range(0, 150);
          r_refresh = $urandom_range(0, 400);
          step_max  = $urandom_range(5, 40);
        end
      endcase
      if (ph >= 2) now_clock = r_boot + $urandom_range(0, 40);

      // Idle mix: clean, sender idling, receiver stalling, both.
      case (ph % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 76; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase

      settle();
      junk = $urandom;
      write_reg(CFG_CRED_COUNT, {junk[31:2], r_cred});
      write_reg(CFG_BOOT_TIME, r_boot);
      write_reg(CFG_BOOT_DELAY, r_delay);
      write_reg(CFG_CONNECT_TIMEOUT, r_conn);
      write_reg(CFG_SERVICE_TIMEOUT, r_svc);
      write_reg(CFG_FAIL_WAIT, r_fail);
      write_reg(CFG_REFRESH, r_refresh);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Fill the block: receiver holds off while items keep coming.
        if (ph == 4 && n == 20) hold_request = 1'b1;
        // Let the pipeline run dry mid-phase.
        if (ph == 5 && n == 40) settle();

        if ($urandom_range(0, 99) < 3) now_clock = $urandom;
        else now_clock = now_clock + $urandom_range(0, step_max);
        it.operation         = ($urandom_range(0, 99) < 6) ? OP_REQUEST : OP_POLL;
        it.now_ms            = now_clock;
        it.host_time_present = ($urandom_range(0, 99) < 20);
        it.link_up           = ($urandom_range(0, 99) < 35);
        it.time_ready        = ($urandom_range(0, 99) < 50);
        it.cand_year         = ($urandom_range(0, 99) < 70) ? 14'($urandom_range(2015, 2100))
                                                            : 14'($urandom_range(0, 9999));
        it.cand_month        = 4'($urandom_range(1, 12));
        it.cand_day          = 5'($urandom_range(1, 31));
        it.cand_hour         = 5'($urandom_range(0, 23));
        it.cand_minute       = 6'($urandom_range(0, 59));
        it.cand_second       = 6'($urandom_range(0, 60));
        send_item(it);
        rand_items++;
      end
    end

    settle();
    repeat (6) @(posedge clk);

    $display("Checked %0d reports: %0d directed and %0d random items under %0d settings,",
             reports_checked, dir_items, rand_items, RAND_PHASES + 3);
    $display("  %0d syncs captured, %0d field mismatches.", syncs_seen, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/lts_pkg.sv
hw/rtl/lts_if.sv
hw/rtl/lts_cfg_regs.sv
hw/rtl/lts_step.sv
hw/rtl/link_time_sync_supervisor_core.sv
tb/link_time_sync_supervisor_core_tb.sv
